@@ rtl/v3n_pkg.sv @@
// ----------------------------------------------------------------------------
// v3n_pkg: shared constants for the vector normalizer
// Holds the fixed output formats of the normalizer: the Q1.14 unit
// components, the quotient width and the saturating length field.
// ----------------------------------------------------------------------------
`default_nettype none

package v3n_pkg;

    localparam int UNIT_FRACTION = 14;
    localparam int QUOT_W        = UNIT_FRACTION + 1;
    localparam int UNIT_W        = 16;
    localparam int LENGTH_W      = 16;
    localparam int LANES         = 3;

    localparam logic [LENGTH_W-1:0] LENGTH_MAX = '1;

endpackage

`default_nettype wire

@@ rtl/v3n_square.sv @@
// ----------------------------------------------------------------------------
// v3n_square: magnitude, square and sum front end
// Three register stages: component magnitudes and signs, the three squares,
// and their exact sum.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_square #(
    parameter int COMP_W = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     en,
    input  wire logic                                     in_valid,
    input  wire logic signed [COMP_W-1:0]                 comp_x,
    input  wire logic signed [COMP_W-1:0]                 comp_y,
    input  wire logic signed [COMP_W-1:0]                 comp_z,
    output logic                                          out_valid,
    output logic [2*COMP_W+1:0]                           sum,
    output logic [v3n_pkg::LANES-1:0][COMP_W-1:0]         mag,
    output logic [v3n_pkg::LANES-1:0]                     neg
);
    import v3n_pkg::*;

    logic [LANES-1:0][COMP_W-1:0]   comp_all;
    logic [LANES-1:0][COMP_W-1:0]   mag1_next;
    logic [LANES-1:0]               neg1_next;
    logic [LANES-1:0][COMP_W-1:0]   mag1_reg;
    logic [LANES-1:0]               neg1_reg;
    logic [LANES-1:0][2*COMP_W-1:0] sq2_next;
    logic [LANES-1:0][2*COMP_W-1:0] sq2_reg;
    logic [LANES-1:0][COMP_W-1:0]   mag2_reg;
    logic [LANES-1:0]               neg2_reg;
    logic [2*COMP_W+1:0]            sum3_next;
    logic [2*COMP_W+1:0]            sum3_reg;
    logic [LANES-1:0][COMP_W-1:0]   mag3_reg;
    logic [LANES-1:0]               neg3_reg;
    logic [2:0]                     valid_reg;

    assign comp_all = {comp_z, comp_y, comp_x};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            neg1_next[i] = comp_all[i][COMP_W-1];
            mag1_next[i] = comp_all[i][COMP_W-1] ? COMP_W'(0) - comp_all[i] : comp_all[i];
            sq2_next[i]  = (2*COMP_W)'(mag1_reg[i]) * (2*COMP_W)'(mag1_reg[i]);
        end
        sum3_next = (2*COMP_W+2)'(sq2_reg[0]) + (2*COMP_W+2)'(sq2_reg[1])
                  + (2*COMP_W+2)'(sq2_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
            sq2_reg  <= sq2_next;
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            sum3_reg <= sum3_next;
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign sum       = sum3_reg;
    assign mag       = mag3_reg;
    assign neg       = neg3_reg;

endmodule

`default_nettype wire

@@ rtl/v3n_sqrt.sv @@
// ----------------------------------------------------------------------------
// v3n_sqrt: pipelined integer square root
// Digit-by-digit square root that settles one root bit per register stage
// and carries a sideband word alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_sqrt #(
    parameter int ROOT_W = 17,
    parameter int SIDE_W = 51
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic                       out_valid,
    output logic [ROOT_W-1:0]          root,
    output logic [SIDE_W-1:0]          side_out
);

    logic [2*ROOT_W-1:0] rad_w   [0:ROOT_W];
    logic [ROOT_W+1:0]   rem_w   [0:ROOT_W];
    logic [ROOT_W-1:0]   root_w  [0:ROOT_W];
    logic [SIDE_W-1:0]   side_w  [0:ROOT_W];
    logic                valid_w [0:ROOT_W];

    assign rad_w[0]   = radicand;
    assign rem_w[0]   = '0;
    assign root_w[0]  = '0;
    assign side_w[0]  = side_in;
    assign valid_w[0] = in_valid;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [ROOT_W+1:0]   rem_sh;
        logic [ROOT_W+1:0]   trial;
        logic                ge;
        logic [2*ROOT_W-1:0] rad_next;
        logic [ROOT_W+1:0]   rem_next;
        logic [ROOT_W-1:0]   root_next;
        logic [2*ROOT_W-1:0] rad_reg;
        logic [ROOT_W+1:0]   rem_reg;
        logic [ROOT_W-1:0]   root_reg;
        logic [SIDE_W-1:0]   side_reg;
        logic                valid_reg;

        always_comb
        begin
            rem_sh    = {rem_w[k][ROOT_W-1:0], rad_w[k][2*ROOT_W-1 -: 2]};
            trial     = {root_w[k], 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? rem_sh - trial : rem_sh;
            root_next = {root_w[k][ROOT_W-2:0], ge};
            rad_next  = {rad_w[k][2*ROOT_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg  <= rad_next;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                side_reg <= side_w[k];
            end
        end

        assign rad_w[k+1]   = rad_reg;
        assign rem_w[k+1]   = rem_reg;
        assign root_w[k+1]  = root_reg;
        assign side_w[k+1]  = side_reg;
        assign valid_w[k+1] = valid_reg;
    end

    assign out_valid = valid_w[ROOT_W];
    assign root      = root_w[ROOT_W];
    assign side_out  = side_w[ROOT_W];

endmodule

`default_nettype wire

@@ rtl/v3n_divide.sv @@
// ----------------------------------------------------------------------------
// v3n_divide: pipelined three-lane divider
// Restoring division of each component magnitude by the length, one
// quotient bit per register stage, giving the Q1.14 magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_divide #(
    parameter int COMP_W = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          en,
    input  wire logic                                          in_valid,
    input  wire logic [COMP_W-1:0]                             len_in,
    input  wire logic [v3n_pkg::LANES-1:0][COMP_W-1:0]         mag,
    input  wire logic [v3n_pkg::LANES-1:0]                     neg_in,
    output logic                                               out_valid,
    output logic [COMP_W-1:0]                                  len_out,
    output logic [v3n_pkg::LANES-1:0][v3n_pkg::QUOT_W-1:0]     quot,
    output logic [v3n_pkg::LANES-1:0]                          neg_out
);
    import v3n_pkg::*;

    logic [LANES-1:0][COMP_W-1:0] rem_w   [0:QUOT_W];
    logic [LANES-1:0][QUOT_W-1:0] quot_w  [0:QUOT_W];
    logic [COMP_W-1:0]            len_w   [0:QUOT_W];
    logic [LANES-1:0]             neg_w   [0:QUOT_W];
    logic                         valid_w [0:QUOT_W];

    assign rem_w[0]   = mag;
    assign quot_w[0]  = '0;
    assign len_w[0]   = len_in;
    assign neg_w[0]   = neg_in;
    assign valid_w[0] = in_valid;

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_stage
        logic [LANES-1:0][COMP_W:0]   rem_sh;
        logic [LANES-1:0]             ge;
        logic [LANES-1:0][COMP_W-1:0] rem_next;
        logic [LANES-1:0][QUOT_W-1:0] quot_next;
        logic [LANES-1:0][COMP_W-1:0] rem_reg;
        logic [LANES-1:0][QUOT_W-1:0] quot_reg;
        logic [COMP_W-1:0]            len_reg;
        logic [LANES-1:0]             neg_reg;
        logic                         valid_reg;

        always_comb
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (k == 0)
                begin
                    rem_sh[i] = {1'b0, rem_w[k][i]};
                end
                else
                begin
                    rem_sh[i] = {rem_w[k][i], 1'b0};
                end
                ge[i]        = (rem_sh[i] >= {1'b0, len_w[k]});
                rem_next[i]  = ge[i] ? COMP_W'(rem_sh[i] - {1'b0, len_w[k]})
                                     : rem_sh[i][COMP_W-1:0];
                quot_next[i] = {quot_w[k][i][QUOT_W-2:0], ge[i]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                quot_reg <= quot_next;
                len_reg  <= len_w[k];
                neg_reg  <= neg_w[k];
            end
        end

        assign rem_w[k+1]   = rem_reg;
        assign quot_w[k+1]  = quot_reg;
        assign len_w[k+1]   = len_reg;
        assign neg_w[k+1]   = neg_reg;
        assign valid_w[k+1] = valid_reg;
    end

    assign out_valid = valid_w[QUOT_W];
    assign len_out   = len_w[QUOT_W];
    assign quot      = quot_w[QUOT_W];
    assign neg_out   = neg_w[QUOT_W];

endmodule

`default_nettype wire

@@ rtl/vector3_normalize.sv @@
// ----------------------------------------------------------------------------
// vector3_normalize: 3D vector normalizer
// Turns one signed fixed-point vector per item into its Q1.14 unit vector
// and its truncated Euclidean length, with a flag for the zero vector.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle unless in_stall is high,
// and passes it through these stages in order: three stages
// form the squares and their sum, the square root settles one bit per stage
// over COMPONENT_WIDTH + 1 stages, the divider settles one quotient bit per
// stage over 15 stages, and an output register holds the result. When
// out_stall holds a waiting result, the whole pipeline freezes and in_stall
// rises in the same cycle; nothing is lost or repeated.
`default_nettype none

module vector3_normalize #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [COMPONENT_WIDTH-1:0]    comp_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0]    comp_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0]    comp_z,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [v3n_pkg::UNIT_W-1:0]         unit_x,
    output logic signed [v3n_pkg::UNIT_W-1:0]         unit_y,
    output logic signed [v3n_pkg::UNIT_W-1:0]         unit_z,
    output logic [v3n_pkg::LENGTH_W-1:0]              length,
    output logic                                      zero_vector
);
    import v3n_pkg::*;

    localparam int W         = COMPONENT_WIDTH;
    localparam int ROOT_W    = W + 1;
    localparam int SIDE_W    = LANES * W + LANES;
    localparam int LEN_EXT_W = (W > LENGTH_W) ? W : LENGTH_W;

    logic                           en;
    logic                           sq_valid;
    logic [2*W+1:0]                 sq_sum;
    logic [LANES-1:0][W-1:0]        sq_mag;
    logic [LANES-1:0]               sq_neg;
    logic [SIDE_W-1:0]              side_in;
    logic                           rt_valid;
    logic [ROOT_W-1:0]              rt_root;
    logic [SIDE_W-1:0]              rt_side;
    logic [LANES-1:0][W-1:0]        rt_mag;
    logic [LANES-1:0]               rt_neg;
    logic                           dv_valid;
    logic [W-1:0]                   dv_len;
    logic [LANES-1:0][QUOT_W-1:0]   dv_quot;
    logic [LANES-1:0]               dv_neg;
    logic [LEN_EXT_W-1:0]           len_ext;
    logic                           zero_next;
    logic [LANES-1:0][UNIT_W-1:0]   unit_next;
    logic [LENGTH_W-1:0]            length_next;
    logic                           out_valid_reg;
    logic [LANES-1:0][UNIT_W-1:0]   unit_reg;
    logic [LENGTH_W-1:0]            length_reg;
    logic                           zero_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    v3n_square #(
        .COMP_W (W)
    ) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .comp_x    (comp_x),
        .comp_y    (comp_y),
        .comp_z    (comp_z),
        .out_valid (sq_valid),
        .sum       (sq_sum),
        .mag       (sq_mag),
        .neg       (sq_neg)
    );

    assign side_in = {sq_neg, sq_mag};

    v3n_sqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .radicand  (sq_sum),
        .side_in   (side_in),
        .out_valid (rt_valid),
        .root      (rt_root),
        .side_out  (rt_side)
    );

    assign rt_mag = rt_side[LANES*W-1:0];
    assign rt_neg = rt_side[SIDE_W-1 -: LANES];

    v3n_divide #(
        .COMP_W (W)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .len_in    (rt_root[W-1:0]),
        .mag       (rt_mag),
        .neg_in    (rt_neg),
        .out_valid (dv_valid),
        .len_out   (dv_len),
        .quot      (dv_quot),
        .neg_out   (dv_neg)
    );

    always_comb
    begin
        len_ext   = LEN_EXT_W'(dv_len);
        zero_next = (dv_len == '0);
        if (len_ext > LEN_EXT_W'(LENGTH_MAX))
        begin
            length_next = LENGTH_MAX;
        end
        else
        begin
            length_next = len_ext[LENGTH_W-1:0];
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (zero_next)
            begin
                unit_next[i] = '0;
            end
            else if (dv_neg[i])
            begin
                unit_next[i] = UNIT_W'(0) - UNIT_W'(dv_quot[i]);
            end
            else
            begin
                unit_next[i] = UNIT_W'(dv_quot[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg   <= unit_next;
            length_reg <= length_next;
            zero_reg   <= zero_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign unit_x      = unit_reg[0];
    assign unit_y      = unit_reg[1];
    assign unit_z      = unit_reg[2];
    assign length      = length_reg;
    assign zero_vector = zero_reg;

endmodule

`default_nettype wire

@@ dv/vector3_normalize_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_normalize_tb: self-checking bench for the 3D vector normalizer
// Drives a table of directed vectors and then about 550 random ones through
// the valid/stall handshake. Random idling and stalling come from both sides,
// with one long output hold and two full drains. Every result is checked field
// by field against the table's expected values or, for the untyped vectors, a
// predictor built on the integer square root and the truncating divide.
// ----------------------------------------------------------------------------

module vector3_normalize_tb;

    import v3n_pkg::*;

    localparam int COMP_W       = 16;
    localparam int PIPE_LATENCY = 36;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIR_COUNT    = 24;

    typedef struct packed {
        logic [UNIT_W-1:0]   ux;
        logic [UNIT_W-1:0]   uy;
        logic [UNIT_W-1:0]   uz;
        logic [LENGTH_W-1:0] len;
        logic                zero;
    } norm_result_t;

    typedef struct packed {
        logic [COMP_W-1:0] cx;
        logic [COMP_W-1:0] cy;
        logic [COMP_W-1:0] cz;
        logic              typed;
        norm_result_t      want;
    } vec_case_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [COMP_W-1:0] comp_x = '0;
    logic [COMP_W-1:0] comp_y = '0;
    logic [COMP_W-1:0] comp_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [UNIT_W-1:0] unit_x;
    logic [UNIT_W-1:0] unit_y;
    logic [UNIT_W-1:0] unit_z;
    logic [LENGTH_W-1:0] length;
    logic zero_vector;

    norm_result_t pending_units [$];
    norm_result_t oldest_unit;
    int error_count = 0;
    int results_seen = 0;
    int zero_seen = 0;
    int input_stalls = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;
    bit steady = 1'b0;
    bit long_hold_req = 1'b0;

    vec_case_t dir_cases [DIR_COUNT] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1,
          '{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1}},
        '{16'd256, 16'h0000, 16'h0000, 1'b1,
          '{16'sd16384, 16'sd0, 16'sd0, 16'd256, 1'b0}},
        '{16'h8000, 16'h0000, 16'h0000, 1'b1,
          '{-16'sd16384, 16'sd0, 16'sd0, 16'd32768, 1'b0}},
        '{16'h7FFF, 16'h0000, 16'h0000, 1'b1,
          '{16'sd16384, 16'sd0, 16'sd0, 16'd32767, 1'b0}},
        '{16'h0000, 16'h8000, 16'h0000, 1'b1,
          '{16'sd0, -16'sd16384, 16'sd0, 16'd32768, 1'b0}},
        '{16'h0000, 16'h7FFF, 16'h0000, 1'b1,
          '{16'sd0, 16'sd16384, 16'sd0, 16'd32767, 1'b0}},
        '{16'h0000, 16'h0000, 16'h8000, 1'b1,
          '{16'sd0, 16'sd0, -16'sd16384, 16'd32768, 1'b0}},
        '{16'h0000, 16'h0000, 16'h7FFF, 1'b1,
          '{16'sd0, 16'sd0, 16'sd16384, 16'd32767, 1'b0}},
        '{16'h0001, 16'h0000, 16'h0000, 1'b1,
          '{16'sd16384, 16'sd0, 16'sd0, 16'd1, 1'b0}},
        '{16'h0000, 16'h0000, 16'hFFFF, 1'b1,
          '{16'sd0, 16'sd0, -16'sd16384, 16'd1, 1'b0}},
        '{16'h8000, 16'h8000, 16'h8000, 1'b1,
          '{-16'sd9459, -16'sd9459, -16'sd9459, 16'd56755, 1'b0}},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
        '{16'h0001, 16'h0001, 16'h0001, 1'b1,
          '{16'sd16384, 16'sd16384, 16'sd16384, 16'd1, 1'b0}},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
          '{-16'sd16384, -16'sd16384, -16'sd16384, 16'd1, 1'b0}},
        '{16'd3, 16'd4, 16'h0000, 1'b0, '0},
        '{16'd768, 16'd1024, 16'h0000, 1'b0, '0},
        '{16'h8000, 16'h7FFF, 16'h0000, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 16'h7FFF, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 16'h8000, 1'b0, '0},
        '{16'h0000, 16'h0000, 16'h0000, 1'b1,
          '{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1}},
        '{16'd255, 16'd255, 16'd255, 1'b0, '0},
        '{16'hFF00, 16'hFF00, 16'hFF00, 1'b0, '0},
        '{16'd12345, -16'sd23456, 16'd7, 1'b0, '0},
        '{16'hFFFF, 16'h7FFF, 16'h8000, 1'b0, '0}
    };

    vector3_normalize #(
        .COMPONENT_WIDTH(COMP_W)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .comp_x      (comp_x),
        .comp_y      (comp_y),
        .comp_z      (comp_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .unit_x      (unit_x),
        .unit_y      (unit_y),
        .unit_z      (unit_z),
        .length      (length),
        .zero_vector (zero_vector)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] comp_mag(logic [COMP_W-1:0] raw);
        if (raw[COMP_W-1])
        begin
            return (64'h1 << COMP_W) - {48'd0, raw};
        end
        return {48'd0, raw};
    endfunction

    function automatic logic [UNIT_W-1:0] unit_lane(logic [63:0] mag, logic neg,
                                                    logic [63:0] len);
        logic [63:0] quo;
        quo = (len == 64'd0) ? 64'd0 : (mag << UNIT_FRACTION) / len;
        if (neg)
        begin
            quo = 64'd0 - quo;
        end
        return quo[UNIT_W-1:0];
    endfunction

    function automatic norm_result_t normalize_vec(logic [COMP_W-1:0] cx,
                                                   logic [COMP_W-1:0] cy,
                                                   logic [COMP_W-1:0] cz);
        logic [63:0] mx;
        logic [63:0] my;
        logic [63:0] mz;
        logic [63:0] rest;
        logic [63:0] root;
        logic [63:0] probe;
        norm_result_t res;
        mx = comp_mag(cx);
        my = comp_mag(cy);
        mz = comp_mag(cz);
        rest = mx * mx + my * my + mz * mz;
        root = 64'd0;
        probe = 64'h1 << 62;
        while (probe > rest)
        begin
            probe = probe >> 2;
        end
        while (probe != 64'd0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        res.ux = unit_lane(mx, cx[COMP_W-1], root);
        res.uy = unit_lane(my, cy[COMP_W-1], root);
        res.uz = unit_lane(mz, cz[COMP_W-1], root);
        res.len = (root > 64'hFFFF) ? LENGTH_MAX : root[LENGTH_W-1:0];
        res.zero = (root == 64'd0);
        return res;
    endfunction

    function automatic logic [COMP_W-1:0] pick_comp();
        logic [COMP_W-1:0] raw;
        raw = 16'($urandom);
        case ($urandom_range(0, 5))
            0, 1:
            begin
                return raw;
            end
            2:
            begin
                return 16'(int'($urandom_range(0, 16)) - 8);
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            4:
            begin
                return {{7{raw[8]}}, raw[8:0]};
            end
            default:
            begin
                return 16'h0000;
            end
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic offer_vector(input logic [COMP_W-1:0] cx, input logic [COMP_W-1:0] cy,
                                input logic [COMP_W-1:0] cz, input logic typed,
                                input norm_result_t want);
        int unsigned gap;
        if (!quiet && !steady && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        comp_x <= cx;
        comp_y <= cy;
        comp_z <= cz;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_units.push_back(typed ? want : normalize_vec(cx, cy, cz));
    endtask

    task automatic offer_random(input int count);
        logic [COMP_W-1:0] vx;
        logic [COMP_W-1:0] vy;
        logic [COMP_W-1:0] vz;
        for (int i = 0; i < count; i++)
        begin
            vx = pick_comp();
            vy = pick_comp();
            vz = pick_comp();
            case ($urandom_range(0, 7))
                0:
                begin
                    vy = 16'h0000;
                    vz = 16'h0000;
                end
                1:
                begin
                    vy = vx;
                    vz = vx;
                end
                default:
                begin
                end
            endcase
            offer_vector(vx, vy, vz, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out with %0d results still pending.", pending_units.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (in_valid && in_stall)
        begin
            input_stalls++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_units.size() == 0)
            begin
                report_error("result arrived with nothing pending");
            end
            else
            begin
                oldest_unit = pending_units.pop_front();
                if (unit_x !== oldest_unit.ux)
                begin
                    report_error($sformatf("unit_x want %h got %h", oldest_unit.ux, unit_x));
                end
                if (unit_y !== oldest_unit.uy)
                begin
                    report_error($sformatf("unit_y want %h got %h", oldest_unit.uy, unit_y));
                end
                if (unit_z !== oldest_unit.uz)
                begin
                    report_error($sformatf("unit_z want %h got %h", oldest_unit.uz, unit_z));
                end
                if (length !== oldest_unit.len)
                begin
                    report_error($sformatf("length want %h got %h", oldest_unit.len, length));
                end
                if (zero_vector !== oldest_unit.zero)
                begin
                    report_error($sformatf("zero_vector want %b got %b",
                                           oldest_unit.zero, zero_vector));
                end
                if (oldest_unit.zero)
                begin
                    zero_seen++;
                end
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                for (int held = 0; held < HOLD_CYCLES; held++)
                begin
                    @(posedge clk);
                end
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_COUNT; i++)
        begin
            offer_vector(dir_cases[i].cx, dir_cases[i].cy, dir_cases[i].cz,
                         dir_cases[i].typed, dir_cases[i].want);
        end

        offer_random(200);

        // Let the pipeline run dry, then hold the output while items keep coming.
        in_valid <= 1'b0;
        while (pending_units.size() != 0)
        begin
            @(posedge clk);
        end
        long_hold_req = 1'b1;
        steady = 1'b1;
        offer_random(80);
        steady = 1'b0;

        offer_random(170);
        quiet = 1'b1;
        offer_random(100);

        in_valid <= 1'b0;
        while (pending_units.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        $display("Checked %0d normalized vectors, %0d of them zero vectors.",
                 results_seen, zero_seen);
        $display("Input was held off for %0d cycles under output stalls.", input_stalls);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches found.", error_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ vector3_normalize.f @@
rtl/v3n_pkg.sv
rtl/v3n_square.sv
rtl/v3n_sqrt.sv
rtl/v3n_divide.sv
rtl/vector3_normalize.sv
dv/vector3_normalize_tb.sv
